[hdl/srp_pkg.sv]
// Shared types and constants for the shift-reduce expression parser.
// Depends on nothing; srp_front, srp_fifo, srp_back, the top level and the testbench import it.
package srp_pkg;

   localparam int DEPTH_W = 7;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] SYM_ID   = 8'h49;
   localparam logic [7:0] SYM_E    = 8'h45;
   localparam logic [7:0] SYM_PLUS = 8'h2B;
   localparam logic [7:0] SYM_STAR = 8'h2A;
   localparam logic [7:0] SYM_LPAR = 8'h28;
   localparam logic [7:0] SYM_RPAR = 8'h29;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_D     = 8'h64;

   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Work for the back end: up to two shifts, then a result.
   typedef struct packed {
      logic       has_a;
      logic [7:0] sym_a;
      logic       has_b;
      logic [7:0] sym_b;
      logic       is_end;
   } srp_op_type;

endpackage

[hdl/srp_if.sv]
// Valid/ready channel interfaces for the parser's request and response words.
// Depends on nothing.
interface srp_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] ch;
   modport source (output valid, output cmd, output ch, input ready);
   modport sink (input valid, input cmd, input ch, output ready);
endinterface

interface srp_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] depth;
   logic       overflow;
   logic       finished;
   logic       accepted;
   modport source (output valid, output depth, output overflow, output finished,
                   output accepted, input ready);
   modport sink (input valid, input depth, input overflow, input finished,
                 input accepted, output ready);
endinterface

[hdl/srp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module srp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[hdl/srp_front.sv]
// Front end: takes request words, pairs 'i' with 'd' and turns each word into shift work.
// Depends on srp_pkg and srp_if.
module srp_front (
   input  logic                clock,
   input  logic                reset,
   srp_req_if.sink             req,
   output logic                op_valid,
   output srp_pkg::srp_op_type op_data,
   input  logic                op_ready
);
   import srp_pkg::*;

   logic pend_ff;
   logic pend_in;
   logic take;

   assign req.ready = op_ready;
   assign take      = req.valid && op_ready;
   assign op_valid  = req.valid;

   always_comb begin
      op_data = '0;
      pend_in = pend_ff;
      if (req.cmd == CMD_END) begin
         op_data.is_end = 1'b1;
         op_data.has_a  = pend_ff;
         op_data.sym_a  = CH_I;
         pend_in        = 1'b0;
      end else if (pend_ff) begin
         op_data.has_a = 1'b1;
         pend_in       = 1'b0;
         if (req.ch == CH_D) begin
            op_data.sym_a = SYM_ID;
         end else begin
            op_data.sym_a = CH_I;
            if (req.ch == CH_I) begin
               pend_in = 1'b1;
            end else begin
               op_data.has_b = 1'b1;
               op_data.sym_b = req.ch;
            end
         end
      end else if (req.ch == CH_I) begin
         // Hold the 'i' until the next byte shows whether it is an id.
         pend_in = 1'b1;
      end else begin
         op_data.has_a = 1'b1;
         op_data.sym_a = req.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (take) begin
         pend_ff <= pend_in;
      end
   end

endmodule

[hdl/srp_fifo.sv]
// Short queue of shift work between the front and back ends.
// Depends on srp_pkg.
module srp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  srp_pkg::srp_op_type push_data,
   output logic                push_ready,
   output logic                pop_valid,
   output srp_pkg::srp_op_type pop_data,
   input  logic                pop
);
   import srp_pkg::*;

   srp_op_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QPTR_W:0]      fill_ff;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = fill_ff != (QPTR_W + 1)'(QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + (QPTR_W + 1)'(1);
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - (QPTR_W + 1)'(1);
         end
      end
   end

endmodule

[hdl/srp_back.sv]
// Back end: stacks symbols, reduces one rule a cycle but for refills, issues response words.
// Depends on srp_pkg, srp_if and srp_ram.
module srp_back #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_valid,
   input  srp_pkg::srp_op_type op_data,
   output logic                op_pop,
   srp_rsp_if.source           rsp
);
   import srp_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SHIFT  = 6'b000010,
      ST_REDUCE = 6'b000100,
      ST_FILL_A = 6'b001000,
      ST_FILL_B = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   // The three topmost stack entries are kept in registers as well as in the RAM.
   logic [7:0]    top0_ff, top0_in;
   logic [7:0]    top1_ff, top1_in;
   logic [7:0]    top2_ff, top2_in;
   srp_op_type    op_ff, op_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [6:0]    depth_ff, depth_in;
   logic          overflow_ff, overflow_in;
   logic          finished_ff, finished_in;
   logic          accepted_ff, accepted_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   logic          full;
   logic [CW-1:0] cnt_m1, cnt_m3, cnt_m4;
   logic          match_id, match_op, match_par;
   logic          out_free;

   srp_ram #(
      .WIDTH (8),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign full      = count_ff == CW'(STACK_DEPTH);
   assign cnt_m1    = count_ff - CW'(1);
   assign cnt_m3    = count_ff - CW'(3);
   assign cnt_m4    = count_ff - CW'(4);
   assign match_id  = (count_ff >= CW'(1)) && (top0_ff == SYM_ID);
   assign match_op  = (count_ff >= CW'(3)) && (top2_ff == SYM_E) && (top0_ff == SYM_E)
                      && ((top1_ff == SYM_PLUS) || (top1_ff == SYM_STAR));
   assign match_par = (count_ff >= CW'(3)) && (top2_ff == SYM_LPAR) && (top1_ff == SYM_E)
                      && (top0_ff == SYM_RPAR);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      top0_in      = top0_ff;
      top1_in      = top1_ff;
      top2_in      = top2_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      depth_in     = depth_ff;
      overflow_in  = overflow_ff;
      finished_in  = finished_ff;
      accepted_in  = accepted_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = '0;
      op_pop       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (op_valid) begin
               op_pop   = 1'b1;
               op_in    = op_data;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (op_ff.has_a) begin
               if (!full) begin
                  ram_we    = 1'b1;
                  ram_waddr = count_ff[AW-1:0];
                  ram_wdata = op_ff.sym_a;
                  top0_in   = op_ff.sym_a;
                  top1_in   = top0_ff;
                  top2_in   = top1_ff;
                  count_in  = count_ff + CW'(1);
               end else begin
                  // The symbol is dropped, but reductions are still tried.
                  ovf_in = 1'b1;
               end
               op_in.has_a = op_ff.has_b;
               op_in.sym_a = op_ff.sym_b;
               op_in.has_b = 1'b0;
               state_in    = ST_REDUCE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_REDUCE: begin
            if (match_id) begin
               top0_in   = SYM_E;
               ram_we    = 1'b1;
               ram_waddr = cnt_m1[AW-1:0];
               ram_wdata = SYM_E;
            end else if (match_op || match_par) begin
               count_in  = count_ff - CW'(2);
               top0_in   = SYM_E;
               ram_we    = 1'b1;
               ram_waddr = cnt_m3[AW-1:0];
               ram_wdata = SYM_E;
               // Refill the two cached entries below the new top from the RAM.
               ram_raddr = cnt_m4[AW-1:0];
               if (count_ff >= CW'(4)) begin
                  state_in = ST_FILL_A;
               end
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_FILL_A: begin
            top1_in   = ram_rdata;
            ram_raddr = cnt_m3[AW-1:0];
            if (count_ff >= CW'(3)) begin
               state_in = ST_FILL_B;
            end else begin
               state_in = ST_REDUCE;
            end
         end
         ST_FILL_B: begin
            top2_in  = ram_rdata;
            state_in = ST_REDUCE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               depth_in     = 7'(count_ff);
               overflow_in  = ovf_ff;
               finished_in  = op_ff.is_end;
               accepted_in  = op_ff.is_end && (count_ff == CW'(1)) && (top0_ff == SYM_E)
                              && !ovf_ff;
               if (op_ff.is_end) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top0_ff     <= top0_in;
      top1_ff     <= top1_in;
      top2_ff     <= top2_in;
      op_ff       <= op_in;
      depth_ff    <= depth_in;
      overflow_ff <= overflow_in;
      finished_ff <= finished_in;
      accepted_ff <= accepted_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.depth    = depth_ff;
   assign rsp.overflow = overflow_ff;
   assign rsp.finished = finished_ff;
   assign rsp.accepted = accepted_ff;

endmodule

[hdl/shift_reduce_expression_parser_unit.sv]
// Shift-reduce parser for E -> E+E | E*E | (E) | id, fed one byte per request word; every
// request word gives exactly one response word. The front end pairs 'i' with 'd' and queues
// up to four words of shift work, so requests are taken while the back end is busy. The back
// end is a sequencer over a stack RAM whose top three entries are cached in registers: it
// takes a word from the queue, shifts each of its symbols and tries reductions after each
// shift, refills the cache from the RAM when a three-symbol reduction needs it, and then
// issues the response word. The stack RAM needs no clearing pass after reset.
module shift_reduce_expression_parser_unit #(
   parameter int STACK_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   srp_req_if.sink    req_chan,
   srp_rsp_if.source  rsp_chan
);
   import srp_pkg::*;

   logic       fr_valid;
   srp_op_type fr_data;
   logic       fr_ready;
   logic       q_valid;
   srp_op_type q_data;
   logic       q_pop;

   srp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .op_valid (fr_valid),
      .op_data  (fr_data),
      .op_ready (fr_ready)
   );

   srp_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_data  (fr_data),
      .push_ready (fr_ready),
      .pop_valid  (q_valid),
      .pop_data   (q_data),
      .pop        (q_pop)
   );

   srp_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (q_valid),
      .op_data  (q_data),
      .op_pop   (q_pop),
      .rsp      (rsp_chan)
   );

endmodule

[hdl/srp_checker.sv]
// Port-level checks on the parser's response channel, bound to the top level.
// Depends on the top level's ports only.
module srp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_depth,
   input logic       rsp_overflow,
   input logic       rsp_finished,
   input logic       rsp_accepted
);

   // A stalled response word holds its place and its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_depth)
         && $stable(rsp_overflow) && $stable(rsp_finished) && $stable(rsp_accepted))
      else $error("response word changed while stalled");

   // Acceptance only ever appears on the word that ends a string.
   a_acc_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_finished)
      else $error("accept flagged on a character word");

   // An accepted string leaves exactly one symbol and saw no overflow.
   a_acc_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_depth == 7'd1 && !rsp_overflow)
      else $error("accept with wrong depth or with overflow");

   // Reset leaves no response word pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind shift_reduce_expression_parser_unit srp_checker u_srp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_depth    (rsp_chan.depth),
   .rsp_overflow (rsp_chan.overflow),
   .rsp_finished (rsp_chan.finished),
   .rsp_accepted (rsp_chan.accepted)
);

[test/srp_parse_checker.sv]
// Checker for the shift-reduce expression parser: watches both channels, predicts each
// response word from the request words it sees and compares them field by field.
// Depends on srp_pkg and the channel interfaces in srp_if.sv.
module srp_parse_checker
   import srp_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   srp_req_if   req_chan,
   srp_rsp_if   rsp_chan,
   output int   mismatches,
   output int   owed
);

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic               overflow;
      logic               finished;
      logic               accepted;
   } parse_word_t;

   logic [7:0]  sym_stack [STACK_DEPTH];
   int unsigned sym_count = 0;
   logic        pend_i = 1'b0;
   logic        ovf_seen = 1'b0;
   parse_word_t expected_words [$];
   int          fail_count = 0;

   initial begin
      mismatches = 0;
      owed = 0;
   end

   // Reductions are retried from the top rule each time one fires.
   function automatic void collapse_stack();
      int unsigned n;
      bit          busy;
      busy = 1'b1;
      while (busy) begin
         n = sym_count;
         if (n >= 1 && sym_stack[n-1] == SYM_ID) begin
            sym_stack[n-1] = SYM_E;
         end else if (n >= 3 && sym_stack[n-3] == SYM_E &&
                      (sym_stack[n-2] == SYM_PLUS || sym_stack[n-2] == SYM_STAR) &&
                      sym_stack[n-1] == SYM_E) begin
            sym_count = n - 2;
            sym_stack[n-3] = SYM_E;
         end else if (n >= 3 && sym_stack[n-3] == SYM_LPAR &&
                      sym_stack[n-2] == SYM_E && sym_stack[n-1] == SYM_RPAR) begin
            sym_count = n - 2;
            sym_stack[n-3] = SYM_E;
         end else begin
            busy = 1'b0;
         end
      end
   endfunction

   // A symbol pushed onto a full stack is lost, but the overflow is remembered.
   function automatic void push_symbol(logic [7:0] sym);
      if (sym_count < STACK_DEPTH) begin
         sym_stack[sym_count] = sym;
         sym_count++;
      end else begin
         ovf_seen = 1'b1;
      end
      collapse_stack();
   endfunction

   function automatic parse_word_t parse_word(logic cmd, logic [7:0] ch);
      parse_word_t r;
      r = '0;
      if (cmd == CMD_CHAR) begin
         if (pend_i) begin
            pend_i = 1'b0;
            if (ch == CH_D) begin
               push_symbol(SYM_ID);
            end else begin
               push_symbol(CH_I);
               if (ch == CH_I) pend_i = 1'b1;
               else push_symbol(ch);
            end
         end else if (ch == CH_I) begin
            pend_i = 1'b1;
         end else begin
            push_symbol(ch);
         end
      end else if (pend_i) begin
         pend_i = 1'b0;
         push_symbol(CH_I);
      end
      r.depth = DEPTH_W'(sym_count);
      r.overflow = ovf_seen;
      r.finished = (cmd == CMD_END);
      r.accepted = (cmd == CMD_END) && sym_count == 1 && sym_stack[0] == SYM_E && !ovf_seen;
      if (cmd == CMD_END) begin
         sym_count = 0;
         pend_i = 1'b0;
         ovf_seen = 1'b0;
      end
      return r;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : watch
      parse_word_t want;
      if (reset) begin
         sym_count = 0;
         pend_i = 1'b0;
         ovf_seen = 1'b0;
         expected_words.delete();
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_words.push_back(parse_word(req_chan.cmd, req_chan.ch));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_words.size() == 0) begin
               $error("response word with nothing expected: depth %0d, finished %0d",
                      rsp_chan.depth, rsp_chan.finished);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("depth", 8'(want.depth), 8'(rsp_chan.depth));
               check_field("overflow", 8'(want.overflow), 8'(rsp_chan.overflow));
               check_field("finished", 8'(want.finished), 8'(rsp_chan.finished));
               check_field("accepted", 8'(want.accepted), 8'(rsp_chan.accepted));
            end
         end
      end
      mismatches <= fail_count;
      owed <= expected_words.size();
   end

endmodule

[test/shift_reduce_expression_parser_unit_tb.sv]
// Top of the parser testbench: clock, reset, request strings and response back-pressure.
// Depends on srp_pkg, srp_if.sv, the parser block and srp_parse_checker.
module shift_reduce_expression_parser_unit_tb;
   import srp_pkg::*;

   localparam int STACK_DEPTH = 64;
   localparam int ITEMS = 650;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef logic [7:0] byte_q_t [$];

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches;
   int   owed;
   int   src_idle_pct = 35;
   int   snk_idle_pct = 79;
   int   items_sent = 0;
   int   hold_requests = 0;
   int   holds_served = 0;
   int   hold_left = 0;
   int   cycle_count = 0;

   srp_req_if req_chan ();
   srp_rsp_if rsp_chan ();

   shift_reduce_expression_parser_unit #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   srp_parse_checker #(.STACK_DEPTH(STACK_DEPTH)) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .mismatches (mismatches),
      .owed       (owed)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Response side: random back-pressure, with a long hold-off whenever one is asked for.
   always @(posedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
   end

   // Valid stays high from one word to the next unless a gap is drawn.
   task automatic send_word(input logic cmd, input logic [7:0] ch);
      if ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         req_chan.cmd   <= 1'($urandom);
         req_chan.ch    <= 8'($urandom);
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= cmd;
      req_chan.ch    <= ch;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic send_string(input byte_q_t s);
      foreach (s[k]) send_word(CMD_CHAR, s[k]);
      send_word(CMD_END, 8'($urandom));
   endtask

   task automatic pause_until_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (owed != 0);
   endtask

   function automatic byte_q_t to_bytes(string t);
      byte_q_t s;
      for (int k = 0; k < t.len(); k++) s.push_back(t[k]);
      return s;
   endfunction

   function automatic void grow_expr(ref byte_q_t s, input int lvl);
      int unsigned pick;
      pick = $urandom_range(99);
      if (lvl == 0 || pick < 40) begin
         // A raw I byte reduces just like a proper id token.
         if ($urandom_range(9) == 0) begin
            s.push_back(SYM_ID);
         end else begin
            s.push_back(CH_I);
            s.push_back(CH_D);
         end
      end else if (pick < 80) begin
         grow_expr(s, lvl - 1);
         s.push_back(pick < 60 ? SYM_PLUS : SYM_STAR);
         grow_expr(s, lvl - 1);
      end else begin
         s.push_back(SYM_LPAR);
         grow_expr(s, lvl - 1);
         s.push_back(SYM_RPAR);
      end
   endfunction

   // Mostly open brackets, which never reduce, so the stack runs close to, up to or past full.
   function automatic byte_q_t deep_string();
      byte_q_t s;
      int      len;
      len = $urandom_range(60, 68);
      repeat (len) s.push_back($urandom_range(9) == 0 ? 8'($urandom) : SYM_LPAR);
      if ($urandom_range(1) == 1) begin
         s.push_back(CH_I);
         s.push_back(CH_D);
      end
      return s;
   endfunction

   function automatic byte_q_t random_string();
      byte_q_t     s;
      int unsigned pick;
      int unsigned k;
      pick = $urandom_range(99);
      if (pick < 2) return deep_string();
      if (pick < 12) begin
         repeat ($urandom_range(1, 8)) s.push_back(8'($urandom));
         return s;
      end
      grow_expr(s, $urandom_range(0, 3));
      if (pick >= 80) begin
         k = $urandom_range(s.size() - 1);
         case ($urandom_range(3))
            0: s.insert(k, 8'($urandom));
            1: s.delete(k);
            2: s.insert(k, CH_I);
            default: while (s.size() > k) void'(s.pop_back());
         endcase
      end
      return s;
   endfunction

   initial begin : stimulus
      byte_q_t s;
      req_chan.valid = 1'b0;
      req_chan.cmd   = CMD_CHAR;
      req_chan.ch    = '0;
      rsp_chan.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_string(to_bytes(""));
      send_string(to_bytes("id"));
      send_string(to_bytes("I+id*(I)"));
      // A trailing lone i is flushed by the end word and the string is rejected.
      send_string(to_bytes("i"));
      send_string(to_bytes("iid"));
      s = {CH_I, 8'hFF, 8'h00};
      send_string(s);

      for (int phase = 0; phase < 3; phase++) begin
         pause_until_drained();
         case (phase)
            0: begin
               src_idle_pct = 35;
               snk_idle_pct = 79;
            end
            1: begin
               src_idle_pct = 79;
               snk_idle_pct = 35;
            end
            default: begin
               src_idle_pct = 0;
               snk_idle_pct = 0;
               hold_requests++;
            end
         endcase
         send_string(deep_string());
         while (items_sent < (phase + 1) * ITEMS / 3) send_string(random_string());
      end

      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && owed == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
